>>> sv/mrav_pkg.sv
package mrav_pkg;

    localparam int MODES          = 16;
    localparam int MODE_BITS      = $clog2(MODES);
    localparam int COS_TABLE_BITS = 10;
    localparam int COS_N          = 1 << COS_TABLE_BITS;
    localparam int COS_QTR        = COS_N / 4;

    localparam longint Q30        = longint'(1) << 30;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint SERIES_DIV [7] = '{182, 132, 90, 56, 30, 12, 2};

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_INC = 32'd1013904223;

    typedef enum logic {
        OP_RENDER = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_MODE_COUNT  = 3'd0,
        REG_LOWPASS     = 3'd1,
        REG_NOISE_DECAY = 3'd2,
        REG_NOISE_START = 3'd3,
        REG_FADE_STEP   = 3'd4,
        REG_ONSET_STEP  = 3'd5,
        REG_NOISE_SEED  = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        COEF_A1         = 3'd0,
        COEF_A2         = 3'd1,
        COEF_GAIN       = 3'd2,
        COEF_DELAY      = 3'd3,
        COEF_LENGTH     = 3'd4,
        COEF_PULSE_GAIN = 3'd5,
        COEF_PHASE_STEP = 3'd6
    } coef_sel_t;

    // First quarter of a cosine period, Q1.30, from a truncated Taylor series.
    typedef logic signed [31:0] cos_tab_t [COS_QTR+1];

    function automatic cos_tab_t cos_build();
        cos_tab_t tab;
        longint   x;
        longint   x2;
        longint   t;
        for (int i = 0; i <= COS_QTR; i++) begin
            x  = (longint'(i) * TWO_PI_Q30) >>> COS_TABLE_BITS;
            x2 = x * x / Q30;
            t  = Q30;
            for (int j = 0; j < 7; j++) begin
                t = Q30 - (x2 * t / Q30) / SERIES_DIV[j];
            end
            if (t > Q30) begin
                t = Q30;
            end
            if (t < -Q30) begin
                t = -Q30;
            end
            tab[i] = 32'(t);
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = cos_build();

    localparam logic [COS_TABLE_BITS:0] COS_Q1 = (COS_TABLE_BITS+1)'(COS_QTR);
    localparam logic [COS_TABLE_BITS:0] COS_Q2 = (COS_TABLE_BITS+1)'(2 * COS_QTR);
    localparam logic [COS_TABLE_BITS:0] COS_Q3 = (COS_TABLE_BITS+1)'(3 * COS_QTR);
    localparam logic [COS_TABLE_BITS:0] COS_Q4 = (COS_TABLE_BITS+1)'(COS_N);

    // Full-period cosine by folding the quarter table.
    function automatic logic signed [31:0] cos_lookup(input logic [COS_TABLE_BITS-1:0] idx);
        logic [COS_TABLE_BITS:0] i;
        logic [COS_TABLE_BITS:0] k;
        logic signed [31:0]      c;
        i = {1'b0, idx};
        if (i <= COS_Q1) begin
            k = i;
            c = COS_TAB[k[COS_TABLE_BITS-2:0]];
        end else if (i <= COS_Q2) begin
            k = COS_Q2 - i;
            c = -COS_TAB[k[COS_TABLE_BITS-2:0]];
        end else if (i <= COS_Q3) begin
            k = i - COS_Q2;
            c = -COS_TAB[k[COS_TABLE_BITS-2:0]];
        end else begin
            k = COS_Q4 - i;
            c = COS_TAB[k[COS_TABLE_BITS-2:0]];
        end
        return c;
    endfunction

endpackage

>>> sv/modal_resonator_attack_voice.sv
// Percussive attack voice: each render word runs up to sixteen two-pole resonators, each
// excited by a delayed Hann pulse, adds lowpassed decaying noise, applies a raised-cosine
// onset ramp and adds the result onto s_in_sample with saturation. Load words write one
// per-mode coefficient and finish in the cycle they are taken. All products go through a
// single registered 33 x 33 bit multiplier under a small sequencer, so a render word runs
// through each active mode's states, then the noise, ramp and output steps; s_ready is low
// for that time. A finished word waits in the output register while the next word may
// already be taken. Coefficients of a mode must be loaded before that mode is rendered.
module modal_resonator_attack_voice
    import mrav_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [3:0]         s_mode_index,
    input  logic [2:0]         s_coef_select,
    input  logic signed [31:0] s_coef_value,
    input  logic signed [23:0] s_in_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_out_sample
);

    typedef enum logic [4:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_LCG_MUL, S_LCG_ADD, S_LP1_MUL, S_LP1_ADD, S_LP2_MUL, S_LP2_ADD,
        S_FADE_MUL, S_FADE_CHK, S_ENV_MUL, S_ENV_SET, S_TERM_MUL, S_TERM_ADD,
        S_DECAY, S_RAMP, S_OUT_HI, S_OUT_LO, S_OUT_SUM
    } state_t;

    localparam logic signed [32:0] Q30_W  = 33'sd1073741824;
    localparam logic signed [47:0] S40_HI = 48'sh007F_FFFF_FFFF;
    localparam logic signed [47:0] S40_LO = -S40_HI - 48'sd1;
    localparam logic signed [36:0] S32_HI = 37'sh0_7FFF_FFFF;
    localparam logic signed [36:0] S32_LO = -S32_HI - 37'sd1;
    localparam logic signed [35:0] S24_HI = 36'sh0_007F_FFFF;
    localparam logic signed [35:0] S24_LO = -S24_HI - 36'sd1;

    function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
        logic signed [47:0] r;
        r = (v > S40_HI) ? S40_HI : ((v < S40_LO) ? S40_LO : v);
        return r[39:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [36:0] r;
        r = (v > S32_HI) ? S32_HI : ((v < S32_LO) ? S32_LO : v);
        return r[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = (v > S24_HI) ? S24_HI : ((v < S24_LO) ? S24_LO : v);
        return r[23:0];
    endfunction

    state_t state_reg;

    // Configuration registers.
    logic [4:0]  mode_count_reg;
    logic [30:0] lowpass_coeff_reg;
    logic [30:0] noise_decay_reg;
    logic [30:0] fade_in_step_reg;
    logic [30:0] onset_phase_step_reg;

    // Per-mode stores.
    logic signed [39:0] res_prev1_reg [MODES];
    logic signed [39:0] res_prev2_reg [MODES];
    logic signed [31:0] fb_coeff1_reg [MODES];
    logic signed [31:0] fb_coeff2_reg [MODES];
    logic signed [31:0] mode_gain_reg [MODES];
    logic [19:0]        pulse_delay_reg [MODES];
    logic [19:0]        pulse_length_reg [MODES];
    logic signed [31:0] pulse_gain_reg [MODES];
    logic [31:0]        pulse_phase_step_reg [MODES];

    // Voice state.
    logic [31:0]        sample_age_reg;
    logic [31:0]        lcg_state_reg;
    logic signed [31:0] lp_stage1_reg;
    logic signed [31:0] lp_stage2_reg;
    logic [31:0]        noise_level_reg;

    // Working registers of the sequencer.
    logic [MODE_BITS-1:0] mode_reg;
    logic [1:0]           draw_reg;
    logic signed [25:0]   noise_sum_reg;
    logic signed [47:0]   total_reg;
    logic signed [39:0]   total_sat_reg;
    logic signed [23:0]   in_sample_reg;
    logic                 in_win_reg;
    logic [30:0]          hann_reg;
    logic signed [32:0]   pulse_x_reg;
    logic signed [71:0]   pacc_reg;
    logic signed [43:0]   yacc_reg;
    logic                 fade_lt_reg;
    logic [29:0]          fade_reg;
    logic [31:0]          env_reg;
    logic [30:0]          ramp_reg;
    logic signed [65:0]   prod_reg;
    logic                 m_valid_reg;
    logic signed [23:0]   m_out_sample_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;

    logic [4:0]         active_modes;
    logic               last_mode;
    logic signed [32:0] age_diff;
    logic               in_win_c;
    logic signed [39:0] y1;
    logic signed [39:0] y2;
    logic [31:0]        step_c;
    logic [31:0]        phase_c;
    logic signed [32:0] hann_sum;
    logic signed [32:0] ramp_sum;
    logic signed [71:0] psum_c;
    logic signed [47:0] y_sum;
    logic signed [39:0] y_new;
    logic signed [31:0] lp_base;
    logic signed [36:0] lp_sum;
    logic [31:0]        lcg_next;
    logic signed [32:0] u_scaled;
    logic signed [35:0] out_sum;
    logic               out_free;

    assign active_modes = (mode_count_reg > 5'(MODES)) ? 5'(MODES) : mode_count_reg;
    assign last_mode    = ({1'b0, mode_reg} == (active_modes - 5'd1));

    assign y1       = res_prev1_reg[mode_reg];
    assign y2       = res_prev2_reg[mode_reg];
    assign step_c   = pulse_phase_step_reg[mode_reg];
    assign age_diff = $signed({1'b0, sample_age_reg}) - $signed({13'b0, pulse_delay_reg[mode_reg]});
    assign in_win_c = !age_diff[32] && (age_diff[31:0] < {12'b0, pulse_length_reg[mode_reg]});

    // The pulse phase is sampled at the middle of each sample step.
    assign phase_c  = prod_reg[31:0] + {1'b0, step_c[31:1]};
    assign hann_sum = Q30_W - 33'(cos_lookup(phase_c[31 -: COS_TABLE_BITS]));
    assign ramp_sum = Q30_W - 33'(cos_lookup(prod_reg[30 -: COS_TABLE_BITS]));

    assign psum_c  = pacc_reg + 72'(prod_reg);
    assign y_sum   = 48'(yacc_reg) + 48'($signed(prod_reg[65:30]));
    assign y_new   = sat40(y_sum);
    assign lp_base = (state_reg == S_LP1_ADD) ? lp_stage1_reg : lp_stage2_reg;
    assign lp_sum  = 37'(lp_base) + 37'($signed(prod_reg[65:30]));
    assign lcg_next = prod_reg[31:0] + LCG_INC;
    assign u_scaled = 33'($signed({noise_sum_reg, 5'b0}));
    assign out_sum  = 36'(in_sample_reg) + 36'($signed(psum_c[71:37]));
    assign out_free = !m_valid_reg || m_ready;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M0: begin
                mul_a = $signed({13'b0, age_diff[19:0]});
                mul_b = $signed({1'b0, step_c});
            end
            S_M1: begin
                mul_a = 33'(fb_coeff1_reg[mode_reg]);
                mul_b = 33'($signed(y1[39:16]));
            end
            S_M2: begin
                mul_a = 33'(fb_coeff1_reg[mode_reg]);
                mul_b = $signed({17'b0, y1[15:0]});
            end
            S_M3: begin
                mul_a = 33'(pulse_gain_reg[mode_reg]);
                mul_b = $signed({2'b0, hann_reg});
            end
            S_M4: begin
                mul_a = 33'(fb_coeff2_reg[mode_reg]);
                mul_b = 33'($signed(y2[39:16]));
            end
            S_M5: begin
                mul_a = 33'(fb_coeff2_reg[mode_reg]);
                mul_b = $signed({17'b0, y2[15:0]});
            end
            S_M6: begin
                mul_a = 33'(mode_gain_reg[mode_reg]);
                mul_b = pulse_x_reg;
            end
            S_LCG_MUL: begin
                mul_a = $signed({1'b0, lcg_state_reg});
                mul_b = $signed({1'b0, LCG_MUL});
            end
            S_LP1_MUL: begin
                mul_a = $signed({2'b0, lowpass_coeff_reg});
                mul_b = u_scaled - 33'(lp_stage1_reg);
            end
            S_LP2_MUL: begin
                mul_a = $signed({2'b0, lowpass_coeff_reg});
                mul_b = 33'(lp_stage1_reg) - 33'(lp_stage2_reg);
            end
            S_FADE_MUL: begin
                mul_a = $signed({1'b0, sample_age_reg});
                mul_b = $signed({2'b0, fade_in_step_reg});
            end
            S_ENV_MUL: begin
                mul_a = $signed({1'b0, noise_level_reg});
                mul_b = $signed({3'b0, fade_reg});
            end
            S_TERM_MUL: begin
                mul_a = $signed({1'b0, env_reg});
                mul_b = 33'(lp_stage2_reg);
            end
            S_TERM_ADD: begin
                mul_a = $signed({1'b0, noise_level_reg});
                mul_b = $signed({2'b0, noise_decay_reg});
            end
            S_DECAY: begin
                mul_a = $signed({1'b0, sample_age_reg});
                mul_b = $signed({2'b0, onset_phase_step_reg});
            end
            S_OUT_HI: begin
                mul_a = $signed({2'b0, ramp_reg});
                mul_b = 33'($signed(total_sat_reg[39:16]));
            end
            S_OUT_LO, S_OUT_SUM: begin
                mul_a = $signed({2'b0, ramp_reg});
                mul_b = $signed({17'b0, total_sat_reg[15:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= S_IDLE;
            mode_count_reg       <= '0;
            lowpass_coeff_reg    <= '0;
            noise_decay_reg      <= '0;
            fade_in_step_reg     <= '0;
            onset_phase_step_reg <= '0;
            sample_age_reg       <= '0;
            lcg_state_reg        <= 32'd1;
            lp_stage1_reg        <= '0;
            lp_stage2_reg        <= '0;
            noise_level_reg      <= '0;
            m_valid_reg          <= 1'b0;
            for (int i = 0; i < MODES; i++) begin
                res_prev1_reg[i] <= '0;
                res_prev2_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_OUT_SUM)) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_write) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MODE_COUNT:  mode_count_reg       <= cfg_data[4:0];
                    REG_LOWPASS:     lowpass_coeff_reg    <= cfg_data[30:0];
                    REG_NOISE_DECAY: noise_decay_reg      <= cfg_data[30:0];
                    REG_NOISE_START: noise_level_reg      <= {1'b0, cfg_data[30:0]};
                    REG_FADE_STEP:   fade_in_step_reg     <= cfg_data[30:0];
                    REG_ONSET_STEP:  onset_phase_step_reg <= cfg_data[30:0];
                    REG_NOISE_SEED:  lcg_state_reg        <= cfg_data;
                    default: begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (op_t'(s_opcode) == OP_LOAD) begin
                            case (coef_sel_t'(s_coef_select))
                                COEF_A1:     fb_coeff1_reg[s_mode_index] <= s_coef_value;
                                COEF_A2:     fb_coeff2_reg[s_mode_index] <= s_coef_value;
                                COEF_GAIN:   mode_gain_reg[s_mode_index] <= s_coef_value;
                                COEF_DELAY:  pulse_delay_reg[s_mode_index] <= s_coef_value[19:0];
                                COEF_LENGTH: pulse_length_reg[s_mode_index] <= s_coef_value[19:0];
                                COEF_PULSE_GAIN: pulse_gain_reg[s_mode_index] <= s_coef_value;
                                COEF_PHASE_STEP: pulse_phase_step_reg[s_mode_index] <= s_coef_value;
                                default: begin
                                end
                            endcase
                        end else begin
                            in_sample_reg <= s_in_sample;
                            mode_reg      <= '0;
                            draw_reg      <= '0;
                            noise_sum_reg <= '0;
                            total_reg     <= '0;
                            state_reg     <= (active_modes == 5'd0) ? S_LCG_MUL : S_M0;
                        end
                    end
                end
                S_M0: begin
                    in_win_reg <= in_win_c;
                    state_reg  <= S_M1;
                end
                S_M1: begin
                    hann_reg  <= hann_sum[31:1];
                    state_reg <= S_M2;
                end
                S_M2: begin
                    pacc_reg  <= 72'(prod_reg) <<< 16;
                    state_reg <= S_M3;
                end
                S_M3: begin
                    yacc_reg  <= 44'($signed(psum_c[71:30]));
                    state_reg <= S_M4;
                end
                S_M4: begin
                    pulse_x_reg <= in_win_reg ? $signed(prod_reg[62:30]) : '0;
                    state_reg   <= S_M5;
                end
                S_M5: begin
                    pacc_reg  <= 72'(prod_reg) <<< 16;
                    state_reg <= S_M6;
                end
                S_M6: begin
                    yacc_reg  <= yacc_reg - 44'($signed(psum_c[71:30]));
                    state_reg <= S_M7;
                end
                S_M7: begin
                    res_prev2_reg[mode_reg] <= y1;
                    res_prev1_reg[mode_reg] <= y_new;
                    total_reg <= total_reg + 48'(y_new);
                    mode_reg  <= mode_reg + 1'b1;
                    state_reg <= last_mode ? S_LCG_MUL : S_M0;
                end
                S_LCG_MUL: begin
                    state_reg <= S_LCG_ADD;
                end
                S_LCG_ADD: begin
                    lcg_state_reg <= lcg_next;
                    noise_sum_reg <= noise_sum_reg + 26'($signed({2'b0, lcg_next[31:8]}))
                                     - 26'sd8388608;
                    draw_reg      <= draw_reg + 1'b1;
                    state_reg     <= (draw_reg == 2'd2) ? S_LP1_MUL : S_LCG_MUL;
                end
                S_LP1_MUL: begin
                    state_reg <= S_LP1_ADD;
                end
                S_LP1_ADD: begin
                    lp_stage1_reg <= sat32(lp_sum);
                    state_reg     <= S_LP2_MUL;
                end
                S_LP2_MUL: begin
                    state_reg <= S_LP2_ADD;
                end
                S_LP2_ADD: begin
                    lp_stage2_reg <= sat32(lp_sum);
                    state_reg     <= S_FADE_MUL;
                end
                S_FADE_MUL: begin
                    state_reg <= S_FADE_CHK;
                end
                S_FADE_CHK: begin
                    fade_lt_reg <= (prod_reg[65:30] == '0);
                    fade_reg    <= prod_reg[29:0];
                    state_reg   <= S_ENV_MUL;
                end
                S_ENV_MUL: begin
                    state_reg <= S_ENV_SET;
                end
                S_ENV_SET: begin
                    env_reg   <= fade_lt_reg ? prod_reg[61:30] : noise_level_reg;
                    state_reg <= S_TERM_MUL;
                end
                S_TERM_MUL: begin
                    state_reg <= S_TERM_ADD;
                end
                S_TERM_ADD: begin
                    total_reg <= total_reg + 48'($signed(prod_reg[65:28]));
                    state_reg <= S_DECAY;
                end
                S_DECAY: begin
                    noise_level_reg <= (|prod_reg[65:62]) ? 32'hFFFF_FFFF : prod_reg[61:30];
                    state_reg       <= S_RAMP;
                end
                S_RAMP: begin
                    // Past the end of the onset half cycle the ramp holds at unity.
                    ramp_reg      <= (prod_reg[65:30] == '0) ? ramp_sum[31:1] : Q30_W[30:0];
                    total_sat_reg <= sat40(total_reg);
                    state_reg     <= S_OUT_HI;
                end
                S_OUT_HI: begin
                    state_reg <= S_OUT_LO;
                end
                S_OUT_LO: begin
                    pacc_reg  <= 72'(prod_reg) <<< 16;
                    state_reg <= S_OUT_SUM;
                end
                S_OUT_SUM: begin
                    if (out_free) begin
                        m_out_sample_reg <= sat24(out_sum);
                        m_valid_reg      <= 1'b1;
                        sample_age_reg   <= sample_age_reg + 32'd1;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_out_sample_reg;

endmodule

>>> verif/tb_modal_resonator_attack_voice.sv
`timescale 1ns / 1ps

module tb_modal_resonator_attack_voice;
    import mrav_pkg::*;

    // Voice predictor together with the store of samples still owed by the block.
    class voice_scoreboard;
        bit [4:0]    mode_count;
        bit [30:0]   lp_coeff, decay, start_level, fade_step, onset_step;
        bit [31:0]   seed, lcg, noise_lvl, age;
        longint      y1 [MODES], y2 [MODES];
        longint      a1 [MODES], a2 [MODES], gain [MODES], pgain [MODES];
        bit [19:0]   delay [MODES], plen [MODES];
        bit [31:0]   pstep [MODES];
        longint      lp1, lp2;
        bit [23:0]   owed [$];
        int          errors;

        function void reset_state();
            mode_count = 0; lp_coeff = 0; decay = 0; start_level = 0;
            fade_step = 0; onset_step = 0; seed = 1;
            lcg = seed; noise_lvl = 0; age = 0; lp1 = 0; lp2 = 0;
            foreach (y1[m]) begin
                y1[m] = 0; y2[m] = 0; a1[m] = 0; a2[m] = 0; gain[m] = 0;
                pgain[m] = 0; delay[m] = 0; plen[m] = 0; pstep[m] = 0;
            end
            owed.delete();
            errors = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, bit [31:0] data);
            case (idx)
                REG_MODE_COUNT:  mode_count = data[4:0];
                REG_LOWPASS:     lp_coeff = data[30:0];
                REG_NOISE_DECAY: decay = data[30:0];
                REG_NOISE_START: begin
                    start_level = data[30:0];
                    noise_lvl = {1'b0, data[30:0]};
                end
                REG_FADE_STEP:   fade_step = data[30:0];
                REG_ONSET_STEP:  onset_step = data[30:0];
                REG_NOISE_SEED:  begin
                    seed = data;
                    lcg = data;
                end
                default: ;
            endcase
        endfunction

        function longint quarter_cos(longint i);
            longint x, x2, t;
            longint divs [7];
            divs = '{182, 132, 90, 56, 30, 12, 2};
            x = (i * 64'sd6746518852) >>> COS_TABLE_BITS;
            x2 = x * x / (64'sd1 << 30);
            t = 64'sd1 << 30;
            for (int j = 0; j < 7; j++) begin
                t = (64'sd1 << 30) - (x2 * t / (64'sd1 << 30)) / divs[j];
            end
            if (t > (64'sd1 << 30)) t = 64'sd1 << 30;
            if (t < -(64'sd1 << 30)) t = -(64'sd1 << 30);
            return t;
        endfunction

        function longint cosine(bit [9:0] idx);
            longint i;
            i = idx;
            if (i <= 256) return quarter_cos(i);
            else if (i <= 512) return -quarter_cos(512 - i);
            else if (i <= 768) return -quarter_cos(i - 512);
            else return quarter_cos(1024 - i);
        endfunction

        function longint mul_q30(longint a, longint b);
            logic signed [79:0] pa, pb, p;
            pa = a;
            pb = b;
            p = pa * pb;
            return longint'(p >>> 30);
        endfunction

        function longint sat(longint v, int w);
            longint hi, lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -(64'sd1 <<< (w - 1));
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function void note_word(op_t op, bit [3:0] mi, bit [2:0] sel, bit [31:0] cv,
                                bit [23:0] ins);
            int        active;
            longint    total, u, d, x, y, h, env, ramp, res, cvs;
            bit [63:0] ph, fade, onset, nl;
            cvs = longint'(signed'(cv));
            if (op == OP_LOAD) begin
                case (sel)
                    COEF_A1:         a1[mi] = cvs;
                    COEF_A2:         a2[mi] = cvs;
                    COEF_GAIN:       gain[mi] = cvs;
                    COEF_DELAY:      delay[mi] = cv[19:0];
                    COEF_LENGTH:     plen[mi] = cv[19:0];
                    COEF_PULSE_GAIN: pgain[mi] = cvs;
                    COEF_PHASE_STEP: pstep[mi] = cv;
                    default: ;
                endcase
                return;
            end
            active = mode_count < MODES ? mode_count : MODES;
            total = 0;
            for (int m = 0; m < active; m++) begin
                d = longint'(age) - longint'(delay[m]);
                x = 0;
                if (d >= 0 && d < longint'(plen[m])) begin
                    ph = 64'(d) * 64'(pstep[m]) + 64'(pstep[m] >> 1);
                    h = ((64'sd1 << 30) - cosine(ph[31:22])) >>> 1;
                    x = (pgain[m] * h) >>> 30;
                end
                y = ((gain[m] * x) >>> 30) + mul_q30(a1[m], y1[m]) - mul_q30(a2[m], y2[m]);
                y = sat(y, 40);
                y2[m] = y1[m];
                y1[m] = y;
                total += y;
            end
            u = 0;
            for (int j = 0; j < 3; j++) begin
                lcg = lcg * 32'd1664525 + 32'd1013904223;
                u += longint'(lcg >> 8) - (64'sd1 << 23);
            end
            u *= 32;
            lp1 = sat(lp1 + ((longint'(lp_coeff) * (u - lp1)) >>> 30), 32);
            lp2 = sat(lp2 + ((longint'(lp_coeff) * (lp1 - lp2)) >>> 30), 32);
            env = longint'(noise_lvl);
            fade = 64'(age) * 64'(fade_step);
            if (fade < (64'd1 << 30)) env = longint'((64'(env) * fade) >> 30);
            total += (env * lp2) >>> 28;
            nl = (64'(noise_lvl) * 64'(decay)) >> 30;
            noise_lvl = nl > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : nl[31:0];
            onset = 64'(age) * 64'(onset_step);
            if (onset < (64'd1 << 30)) ramp = ((64'sd1 << 30) - cosine(onset[30:21])) >>> 1;
            else ramp = 64'sd1 << 30;
            total = sat(total, 40);
            res = sat(longint'(signed'(ins)) + (mul_q30(ramp, total) >>> 7), 24);
            owed.push_back(res[23:0]);
            age++;
        endfunction

        function void check_result(bit [23:0] got);
            bit [23:0] want;
            if (owed.size() == 0) begin
                $error("out_sample: no sample expected, actual %0d", signed'(got));
                errors++;
                return;
            end
            want = owed.pop_front();
            if (want !== got) begin
                $error("out_sample: expected %0d, actual %0d", signed'(want), signed'(got));
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = 1'b0;
    logic [3:0]         s_mode_index = '0;
    logic [2:0]         s_coef_select = '0;
    logic signed [31:0] s_coef_value = '0;
    logic signed [23:0] s_in_sample = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [23:0] m_out_sample;

    voice_scoreboard voice = new();
    bit              calm = 1'b0;

    modal_resonator_attack_voice dut (.*);

    always #4 aclk = ~aclk;

    task automatic write_reg(cfg_reg_t idx, bit [31:0] data);
        @(negedge aclk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge aclk);
        cfg_write = 1'b0;
        voice.write_reg(idx, data);
    endtask

    task automatic send_word(op_t op, bit [3:0] mi, bit [2:0] sel, bit [31:0] cv,
                             bit [23:0] ins);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_opcode = op;
        s_mode_index = mi;
        s_coef_select = sel;
        s_coef_value = cv;
        s_in_sample = ins;
        do @(posedge aclk); while (!s_ready);
        voice.note_word(op, mi, sel, cv, ins);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic load_coef(bit [3:0] mi, coef_sel_t sel, bit wild);
        bit [31:0] v;
        v = $urandom;
        if (!wild) begin
            case (sel)
                COEF_A1:         v = 32'($urandom_range(0, 32'd3865470566)) - 32'd1932735283;
                COEF_A2:         v = $urandom_range(858993459, 1062557696);
                COEF_GAIN:       v = 32'($urandom_range(0, 32'd536870912)) - 32'd268435456;
                COEF_DELAY:      v = $urandom_range(0, 500);
                COEF_LENGTH:     v = $urandom_range(0, 120);
                COEF_PULSE_GAIN: v = 32'($urandom_range(0, 32'd2147483648)) - 32'd1073741824;
                default:         v = $urandom;
            endcase
        end
        send_word(OP_LOAD, mi, sel, v, 24'($urandom));
    endtask

    task automatic render(bit [23:0] ins);
        send_word(OP_RENDER, 4'($urandom), 3'($urandom), $urandom, ins);
    endtask

    // Waits for every owed sample, then idles further with s_valid low.
    task automatic settle();
        s_valid = 1'b0;
        while (voice.owed.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic random_setting();
        bit [31:0] q30;
        q30 = 32'd1 << 30;
        write_reg(REG_MODE_COUNT, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 31));
        write_reg(REG_LOWPASS, $urandom_range(0, 1) ? $urandom_range(0, q30) : q30);
        write_reg(REG_NOISE_DECAY, $urandom_range(0, 1) ? $urandom_range(0, q30) : q30);
        write_reg(REG_NOISE_START, $urandom_range(0, 1) ? $urandom : 32'h7FFF_FFFF);
        write_reg(REG_FADE_STEP, $urandom_range(0, q30 >> 10));
        write_reg(REG_ONSET_STEP, $urandom_range(0, q30 >> 8));
        if ($urandom_range(0, 1)) write_reg(REG_NOISE_SEED, $urandom);
    endtask

    always begin
        @(negedge aclk);
        if (!calm && aresetn && $urandom_range(0, 4) == 0) begin
            m_ready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        m_ready = aresetn;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) voice.check_result(m_out_sample);
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        voice.reset_state();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Every coefficient of every mode is written before any mode is rendered.
        for (int m = 0; m < MODES; m++) begin
            for (int s = COEF_A1; s <= COEF_PHASE_STEP; s++) begin
                load_coef(4'(m), coef_sel_t'(s), 1'b0);
            end
        end

        // Directed: full bank, full-scale noise, sample extremes, invalid selects.
        write_reg(REG_MODE_COUNT, 16);
        write_reg(REG_LOWPASS, 32'd1 << 30);
        write_reg(REG_NOISE_DECAY, 32'd1 << 30);
        write_reg(REG_NOISE_START, 32'h7FFF_FFFF);
        write_reg(REG_FADE_STEP, 32'd1 << 30);
        write_reg(REG_ONSET_STEP, 32'd1 << 30);
        write_reg(REG_NOISE_SEED, 32'hFFFF_FFFF);
        write_reg(cfg_reg_t'(3'd7), 32'hFFFF_FFFF);
        render(24'h7F_FFFF);
        render(24'h80_0000);
        render(24'h00_0000);
        render(24'hFF_FFFF);
        send_word(OP_LOAD, 4'd15, 3'd7, 32'hFFFF_FFFF, 24'h7F_FFFF);
        send_word(OP_LOAD, 4'd0, COEF_DELAY, 32'hFFF0_0000, 24'd0);
        send_word(OP_LOAD, 4'd1, COEF_LENGTH, 32'hFFFF_FFFF, 24'd0);
        send_word(OP_LOAD, 4'd2, COEF_PULSE_GAIN, 32'h8000_0000, 24'd0);
        send_word(OP_LOAD, 4'd3, COEF_A1, 32'h7FFF_FFFF, 24'd0);
        render(24'h12_3456);
        render(24'h80_0000);
        settle();

        // Silent fade and ramp, clamped and zero mode counts.
        write_reg(REG_MODE_COUNT, 31);
        write_reg(REG_FADE_STEP, 0);
        write_reg(REG_ONSET_STEP, 0);
        write_reg(REG_NOISE_DECAY, 0);
        write_reg(REG_NOISE_SEED, 0);
        render(24'h7F_FFFF);
        render(24'h80_0000);
        settle();
        write_reg(REG_MODE_COUNT, 0);
        write_reg(REG_LOWPASS, 0);
        write_reg(REG_NOISE_START, 0);
        render(24'h55_AAAA);
        render(24'hAA_5555);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            random_setting();
            for (int n = 0; n < 80; n++) begin
                if (phase == 5 && n >= 50) calm = 1'b1;
                if ($urandom_range(0, 9) < 3) begin
                    load_coef(4'($urandom), coef_sel_t'($urandom_range(0, 6)),
                              $urandom_range(0, 9) == 0);
                end else if ($urandom_range(0, 19) == 0) begin
                    send_word(OP_LOAD, 4'($urandom), 3'd7, $urandom, 24'($urandom));
                end else begin
                    render(24'($urandom));
                end
            end
            settle();
        end

        if (voice.errors == 0 && voice.owed.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
